// ----- rtl/sva_pkg.sv -----
// Package: shared types, constants and controller/datapath command structs.
`timescale 1ns / 1ps
package sva_pkg;
  localparam int VOICES = 64;
  localparam int VIX_W = $clog2(VOICES);
  localparam int CNT_W = $clog2(VOICES + 1);
  localparam int SAMPLE_SLOTS = 64;
  localparam int POS_BITS = 40;
  localparam int POS_IN_W = 40;
  localparam int TOTAL_W = 32;

  localparam logic [1:0] ACT_TRIGGER = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_PLAY = 2'd1;
  localparam logic [1:0] MODE_REL = 2'd2;

  localparam logic [1:0] PASS_TRACK = 2'd0;
  localparam logic [1:0] PASS_GROUP = 2'd1;
  localparam logic [1:0] PASS_ANY = 2'd2;

  typedef struct packed {
    logic load;
    logic clear;
    logic report;
    logic scan_start;
    logic scan_step;
    logic [1:0] scan_pass;
    logic choke;
    logic assign_voice;
    logic capture;
  } sva_cmd_t;

  typedef struct packed {
    logic trig_ok;
    logic is_trigger;
    logic scan_last;
    logic found;
    logic grp_nonzero;
  } sva_status_t;
endpackage

// ----- rtl/sva_ctrl.sv -----
// Controller: sequences choke, free search and steal passes over the voice table.
`timescale 1ns / 1ps
module sva_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sva_pkg::sva_status_t status,
  output sva_pkg::sva_cmd_t cmd
);
  import sva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PASS = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    cmd.scan_pass = pass_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_trigger && status.trig_ok) begin
          pass_nxt = PASS_TRACK;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end else begin
          cmd.report = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.choke = 1'b1;
        if (status.scan_last) state_nxt = S_PASS;
      end
      S_PASS: begin
        if (status.found) begin
          cmd.assign_voice = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          pass_nxt = (pass_r == PASS_TRACK && status.grp_nonzero) ? PASS_GROUP : PASS_ANY;
          if (pass_r == PASS_ANY) state_nxt = S_DONE;
          else state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.capture = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pass_r <= PASS_TRACK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ----- rtl/sva_datapath.sv -----
// Datapath: voice table, scan counter, best-candidate compare and result registers.
`timescale 1ns / 1ps
module sva_datapath (
  input  logic clk,
  input  logic rst_n,
  input  sva_pkg::sva_cmd_t cmd,
  output sva_pkg::sva_status_t status,
  input  logic [63:0] cfg_wdata,
  input  logic cfg_we,
  input  logic [1:0] in_action,
  input  logic [7:0] in_track,
  input  logic [7:0] in_choke_group,
  input  logic [5:0] in_sample_id,
  input  logic [5:0] in_voice_index,
  input  logic [39:0] in_position,
  input  logic in_finished,
  output logic out_granted,
  output logic [5:0] out_voice,
  output logic out_stolen,
  output logic [6:0] out_choked_count,
  output logic [6:0] out_active_count,
  output logic [31:0] out_stolen_total
);
  import sva_pkg::*;

  logic [SAMPLE_SLOTS-1:0] mask_r;
  logic [1:0] mode_r [VOICES];
  logic [TOTAL_W-1:0] total_r;
  logic [CNT_W-1:0] active_r, choked_r;

  // track/group and position of idle voices are never looked at
  logic [15:0] trkgrp_mem [VOICES];
  logic [POS_BITS-1:0] pos_mem [VOICES];
  logic [15:0] tg_rd_r;
  logic [POS_BITS-1:0] pos_rd_r;

  logic [1:0] act_r;
  logic [7:0] itrk_r, igrp_r;
  logic [5:0] sid_r, vix_r;
  logic [POS_BITS-1:0] ipos_r;
  logic fin_r;

  logic [VIX_W-1:0] idx_r, ev_idx_r;
  logic ev_vld_r;
  logic found_r, best_idle_r, granted_r, stolen_r;
  logic [VIX_W-1:0] best_r;
  logic [POS_BITS-1:0] bpos_r;

  logic [1:0] cm;
  logic cand, idle_hit, is_idle, eval, report_hit;
  logic tg_we, pos_we;
  logic [VIX_W-1:0] rvix, wr_addr;
  logic [POS_BITS-1:0] pos_wdata;

  assign rvix = VIX_W'(vix_r);
  assign cm = mode_r[ev_idx_r];
  assign is_idle = (cm == MODE_IDLE);
  assign idle_hit = is_idle && (cmd.scan_pass == PASS_TRACK);
  assign eval = cmd.scan_step && ev_vld_r;
  always_comb begin
    case (cmd.scan_pass)
      PASS_TRACK: cand = tg_rd_r[15:8] == itrk_r;
      PASS_GROUP: cand = tg_rd_r[7:0] == igrp_r;
      default: cand = 1'b1;
    endcase
    cand = cand && !is_idle;
  end

  assign report_hit = cmd.report && act_r == ACT_REPORT && 32'(vix_r) < VOICES &&
                      mode_r[rvix] != MODE_IDLE;
  assign tg_we = cmd.assign_voice;
  assign pos_we = cmd.assign_voice || (report_hit && !fin_r);
  assign wr_addr = cmd.assign_voice ? best_r : rvix;
  assign pos_wdata = cmd.assign_voice ? '0 : ipos_r;

  assign status.is_trigger = (act_r == ACT_TRIGGER);
  assign status.trig_ok = (32'(sid_r) < SAMPLE_SLOTS) && mask_r[sid_r];
  assign status.scan_last = ev_vld_r && (ev_idx_r == VIX_W'(VOICES - 1));
  assign status.found = found_r;
  assign status.grp_nonzero = (igrp_r != 8'd0);

  always_ff @(posedge clk) begin
    if (tg_we) trkgrp_mem[wr_addr] <= {itrk_r, igrp_r};
    if (pos_we) pos_mem[wr_addr] <= pos_wdata;
    tg_rd_r <= trkgrp_mem[idx_r];
    pos_rd_r <= pos_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      total_r <= '0;
      active_r <= '0;
      for (int i = 0; i < VOICES; i++) begin
        mode_r[i] <= MODE_IDLE;
      end
    end else begin
      if (cfg_we) mask_r <= cfg_wdata[SAMPLE_SLOTS-1:0];
      if (cmd.load) begin
        act_r <= in_action;
        itrk_r <= in_track;
        igrp_r <= in_choke_group;
        sid_r <= in_sample_id;
        vix_r <= in_voice_index;
        ipos_r <= POS_BITS'(in_position);
        fin_r <= in_finished;
        choked_r <= '0;
        granted_r <= 1'b0;
        stolen_r <= 1'b0;
        found_r <= 1'b0;
        best_idle_r <= 1'b0;
      end
      if (cmd.clear && act_r == ACT_CLEAR) begin
        total_r <= '0;
        active_r <= '0;
        for (int i = 0; i < VOICES; i++) begin
          mode_r[i] <= MODE_IDLE;
        end
      end
      if (report_hit && fin_r) begin
        mode_r[rvix] <= MODE_IDLE;
        active_r <= active_r - 1'b1;
      end
      if (cmd.scan_start) begin
        idx_r <= '0;
        ev_vld_r <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r <= idx_r + 1'b1;
        ev_idx_r <= idx_r;
        ev_vld_r <= 1'b1;
      end
      if (eval) begin
        // first pass also chokes and looks for a free voice
        if (cmd.choke && cmd.scan_pass == PASS_TRACK && igrp_r != 8'd0 && !is_idle &&
            tg_rd_r[7:0] == igrp_r) begin
          mode_r[ev_idx_r] <= MODE_REL;
          choked_r <= choked_r + 1'b1;
        end
        if (idle_hit) begin
          if (!best_idle_r) begin
            best_idle_r <= 1'b1;
            found_r <= 1'b1;
            best_r <= ev_idx_r;
          end
        end else if (!best_idle_r && cand && (!found_r || pos_rd_r < bpos_r)) begin
          found_r <= 1'b1;
          best_r <= ev_idx_r;
          bpos_r <= pos_rd_r;
        end
      end
      if (cmd.assign_voice) begin
        mode_r[best_r] <= MODE_PLAY;
        granted_r <= 1'b1;
        if (best_idle_r) active_r <= active_r + 1'b1;
        else begin
          stolen_r <= 1'b1;
          total_r <= total_r + 1'b1;
        end
      end
      if (cmd.capture) begin
        out_granted <= granted_r;
        out_voice <= 6'(best_r & {VIX_W{granted_r}});
        out_stolen <= stolen_r;
        out_choked_count <= 7'(choked_r);
        out_active_count <= 7'(active_r);
        out_stolen_total <= total_r;
      end
    end
  end
endmodule

// ----- rtl/sampler_voice_allocator.sv -----
// Top level: sampler voice allocator with choke groups and voice stealing.
// Usage:
//   Input channel in_* carries one action per transaction (trigger, position
//   report or clear). Result channel out_* returns one result per input
//   transaction, in order. cfg_we/cfg_wdata load the sample valid mask.
// Sequencing:
//   A report or clear does not scan the voice table. A trigger takes
//   one scan of the voice table (table reads are registered; choke, free
//   search and track steal pass together), plus one more scan per
//   further steal pass, up to three scans. The single table scan counter
//   means one transaction is in flight at a time.
// Reset:
//   Synchronous rst_n idles all voices and zeroes the active and stolen counters and mask.
// Stall:
//   While out_stall holds, the result stays registered and the block
//   finishes no further transaction; in_stall stays high while busy.
`timescale 1ns / 1ps
module sampler_voice_allocator (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_track,
  input  logic [7:0] in_choke_group,
  input  logic [5:0] in_sample_id,
  input  logic [5:0] in_voice_index,
  input  logic [39:0] in_position,
  input  logic in_finished,
  output logic out_valid,
  input  logic out_stall,
  output logic out_granted,
  output logic [5:0] out_voice,
  output logic out_stolen,
  output logic [6:0] out_choked_count,
  output logic [6:0] out_active_count,
  output logic [31:0] out_stolen_total
);
  import sva_pkg::*;

  sva_cmd_t cmd;
  sva_status_t status;

  sva_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  sva_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_wdata(cfg_wdata), .cfg_we(cfg_we),
    .in_action(in_action), .in_track(in_track), .in_choke_group(in_choke_group),
    .in_sample_id(in_sample_id), .in_voice_index(in_voice_index),
    .in_position(in_position), .in_finished(in_finished),
    .out_granted(out_granted), .out_voice(out_voice), .out_stolen(out_stolen),
    .out_choked_count(out_choked_count), .out_active_count(out_active_count),
    .out_stolen_total(out_stolen_total)
  );
endmodule

// ----- tb/sva_checker.sv -----
// Checker: watches the allocator's channels, predicts each result and compares.
`timescale 1ns / 1ps
module sva_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic in_valid,
  input  logic in_stall,
  input  logic [1:0] in_action,
  input  logic [7:0] in_track,
  input  logic [7:0] in_choke_group,
  input  logic [5:0] in_sample_id,
  input  logic [5:0] in_voice_index,
  input  logic [39:0] in_position,
  input  logic in_finished,
  input  logic out_valid,
  input  logic out_stall,
  input  logic out_granted,
  input  logic [5:0] out_voice,
  input  logic out_stolen,
  input  logic [6:0] out_choked_count,
  input  logic [6:0] out_active_count,
  input  logic [31:0] out_stolen_total,
  output int fail_count,
  output int outstanding
);
  import sva_pkg::*;

  typedef struct packed {
    logic granted;
    logic [5:0] voice;
    logic stolen;
    logic [6:0] choked;
    logic [6:0] active;
    logic [31:0] total;
  } alloc_result_t;

  logic [1:0] mode_tbl [VOICES];
  logic [7:0] track_tbl [VOICES];
  logic [7:0] group_tbl [VOICES];
  logic [POS_BITS-1:0] pos_tbl [VOICES];
  logic [31:0] steals;
  logic [63:0] valid_mask;
  alloc_result_t expected_results [$];

  function automatic void wipe_voices();
    for (int i = 0; i < VOICES; i++) begin
      mode_tbl[i] = MODE_IDLE;
      track_tbl[i] = '0;
      group_tbl[i] = '0;
      pos_tbl[i] = '0;
    end
    steals = '0;
  endfunction

  // pass 0: same track, 1: same group, 2: any active; lowest position wins
  function automatic int pick_victim(logic [1:0] pass, logic [7:0] trk, logic [7:0] grp);
    int best;
    logic ok;
    best = -1;
    for (int i = 0; i < VOICES; i++) begin
      if (mode_tbl[i] != MODE_IDLE) begin
        if (pass == PASS_TRACK) ok = (track_tbl[i] == trk);
        else if (pass == PASS_GROUP) ok = (group_tbl[i] == grp);
        else ok = 1'b1;
        if (ok && (best < 0 || pos_tbl[i] < pos_tbl[best])) best = i;
      end
    end
    return best;
  endfunction

  function automatic alloc_result_t allocate_step();
    alloc_result_t r;
    int idx;
    int n;
    r = '0;
    idx = -1;
    if (in_action == ACT_TRIGGER) begin
      if (int'(in_sample_id) < SAMPLE_SLOTS && valid_mask[in_sample_id]) begin
        if (in_choke_group != 0)
          for (int i = 0; i < VOICES; i++)
            if (mode_tbl[i] != MODE_IDLE && group_tbl[i] == in_choke_group) begin
              mode_tbl[i] = MODE_REL;
              r.choked++;
            end
        for (int i = VOICES - 1; i >= 0; i--)
          if (mode_tbl[i] == MODE_IDLE) idx = i;
        if (idx < 0) begin
          idx = pick_victim(PASS_TRACK, in_track, in_choke_group);
          if (idx < 0 && in_choke_group != 0)
            idx = pick_victim(PASS_GROUP, in_track, in_choke_group);
          if (idx < 0) idx = pick_victim(PASS_ANY, in_track, in_choke_group);
          if (idx >= 0) begin
            steals++;
            r.stolen = 1'b1;
          end
        end
        if (idx >= 0) begin
          mode_tbl[idx] = MODE_PLAY;
          track_tbl[idx] = in_track;
          group_tbl[idx] = in_choke_group;
          pos_tbl[idx] = '0;
          r.granted = 1'b1;
          r.voice = idx[5:0];
        end
      end
    end else if (in_action == ACT_REPORT) begin
      if (int'(in_voice_index) < VOICES && mode_tbl[in_voice_index] != MODE_IDLE) begin
        if (in_finished) begin
          mode_tbl[in_voice_index] = MODE_IDLE;
          pos_tbl[in_voice_index] = '0;
        end else begin
          pos_tbl[in_voice_index] = in_position[POS_BITS-1:0];
        end
      end
    end else if (in_action == ACT_CLEAR) begin
      wipe_voices();
    end
    n = 0;
    for (int i = 0; i < VOICES; i++)
      if (mode_tbl[i] != MODE_IDLE) n++;
    r.active = n[6:0];
    r.total = steals;
    return r;
  endfunction

  task automatic compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    wipe_voices();
    valid_mask = '0;
  end

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst_n) begin
      wipe_voices();
      valid_mask = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) valid_mask = cfg_wdata;
      if (in_valid && !in_stall) expected_results.push_back(allocate_step());
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with no expectation pending", $time);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          compare_field("granted", e.granted, out_granted);
          compare_field("voice", e.voice, out_voice);
          compare_field("stolen", e.stolen, out_stolen);
          compare_field("choked_count", e.choked, out_choked_count);
          compare_field("active_count", e.active, out_active_count);
          compare_field("stolen_total", e.total, out_stolen_total);
        end
      end
    end
  end
endmodule

// ----- tb/sampler_voice_allocator_tb.sv -----
// Testbench top: drives triggers, reports and clears into the voice allocator.
`timescale 1ns / 1ps
module sampler_voice_allocator_tb;
  import sva_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_TRIGGER;
  logic [7:0] in_track = '0;
  logic [7:0] in_choke_group = '0;
  logic [5:0] in_sample_id = '0;
  logic [5:0] in_voice_index = '0;
  logic [39:0] in_position = '0;
  logic in_finished = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_granted;
  logic [5:0] out_voice;
  logic out_stolen;
  logic [6:0] out_choked_count;
  logic [6:0] out_active_count;
  logic [31:0] out_stolen_total;
  int fail_count;
  int outstanding;

  int sent_cnt = 0;
  int recv_cnt = 0;
  int grant_cnt = 0;
  int steal_cnt = 0;
  int choke_cnt = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  always #5 clk = ~clk;

  sampler_voice_allocator dut (.*);

  sva_checker chk (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      recv_cnt <= recv_cnt + 1;
      if (out_granted) grant_cnt <= grant_cnt + 1;
      if (out_stolen) steal_cnt <= steal_cnt + 1;
      if (out_choked_count != 0) choke_cnt <= choke_cnt + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left <= 400;
    else if (hold_left > 1) hold_left <= hold_left - 1;
    else if (hold_left == 1) begin
      hold_left <= 0;
      hold_req <= 1'b0;
    end
    if (hold_left > 1 || (hold_req && hold_left == 0)) out_stall <= 1'b1;
    else out_stall <= rx_idle_en && ($urandom_range(99) < 25);
  end

  task automatic offer_action(logic [1:0] act, logic [7:0] trk, logic [7:0] grp,
                              logic [5:0] sid, logic [5:0] vix, logic [39:0] pos,
                              logic fin);
    while (tx_idle_en && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_track <= trk;
    in_choke_group <= grp;
    in_sample_id <= sid;
    in_voice_index <= vix;
    in_position <= pos;
    in_finished <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic drain_and_load(logic [63:0] mask);
    in_valid <= 1'b0;
    @(posedge clk);
    while (recv_cnt != sent_cnt) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_action(int narrow);
    int r;
    logic [7:0] trk;
    logic [7:0] grp;
    logic [39:0] pos;
    r = $urandom_range(99);
    trk = narrow ? 8'($urandom_range(3)) : 8'($urandom);
    grp = narrow ? 8'($urandom_range(3)) : 8'($urandom);
    pos = ($urandom_range(1)) ? 40'($urandom_range(15)) : {8'($urandom), 32'($urandom)};
    if (r < 60)
      offer_action(ACT_TRIGGER, trk, grp, 6'($urandom), 6'($urandom), pos, 1'($urandom));
    else if (r < 95)
      offer_action(ACT_REPORT, trk, grp, 6'($urandom), 6'($urandom), pos,
                   $urandom_range(99) < 35);
    else if (r < 97)
      offer_action(2'd3, trk, grp, 6'($urandom), 6'($urandom), pos, 1'($urandom));
    else if (r < 98)
      offer_action(ACT_CLEAR, trk, grp, 6'($urandom), 6'($urandom), pos, 1'($urandom));
    else
      offer_action(ACT_REPORT, trk, grp, 6'($urandom), 6'($urandom), pos, 1'b1);
  endtask

  initial begin
    logic [63:0] masks [6];
    masks[0] = '1;
    masks[1] = {$urandom, $urandom};
    masks[2] = 64'hAAAA_AAAA_AAAA_AAAA;
    masks[3] = '1;
    masks[4] = 64'h5555_5555_5555_5555;
    masks[5] = '1;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // mask zero: triggers dropped; report to idle voice; clear; unused action
    offer_action(ACT_TRIGGER, 8'd1, 8'd1, 6'd0, 6'd0, '0, 1'b0);
    offer_action(ACT_REPORT, 8'd0, 8'd0, 6'd0, 6'd5, 40'd9, 1'b0);
    offer_action(ACT_CLEAR, 8'd0, 8'd0, 6'd0, 6'd0, '0, 1'b0);
    offer_action(2'd3, 8'hFF, 8'hFF, 6'd63, 6'd63, '1, 1'b1);
    drain_and_load(64'h8000_0000_0000_0000);
    offer_action(ACT_TRIGGER, 8'd0, 8'd0, 6'd62, 6'd0, '0, 1'b0);
    offer_action(ACT_TRIGGER, 8'hFF, 8'hFF, 6'd63, 6'd0, '0, 1'b0);
    drain_and_load('1);
    offer_action(ACT_TRIGGER, 8'd0, 8'd0, 6'd0, 6'd0, '0, 1'b0);
    offer_action(ACT_TRIGGER, 8'd2, 8'd7, 6'd10, 6'd0, '0, 1'b0);
    offer_action(ACT_TRIGGER, 8'd3, 8'd7, 6'd11, 6'd0, '0, 1'b0);
    offer_action(ACT_TRIGGER, 8'd4, 8'd7, 6'd12, 6'd0, '0, 1'b0);
    offer_action(ACT_REPORT, 8'd0, 8'd0, 6'd0, 6'd1, '1, 1'b0);
    offer_action(ACT_REPORT, 8'd0, 8'd0, 6'd0, 6'd2, '0, 1'b0);
    offer_action(ACT_REPORT, 8'd0, 8'd0, 6'd0, 6'd0, 40'd5, 1'b1);
    offer_action(ACT_REPORT, 8'd0, 8'd0, 6'd0, 6'd63, 40'd5, 1'b1);
    offer_action(ACT_TRIGGER, 8'hFF, 8'd0, 6'd63, 6'd0, '0, 1'b0);
    offer_action(ACT_CLEAR, 8'd0, 8'd0, 6'd0, 6'd0, '0, 1'b0);
    offer_action(ACT_TRIGGER, 8'd1, 8'hFF, 6'd5, 6'd0, '0, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      drain_and_load(masks[ph]);
      tx_idle_en = (ph != 2);
      rx_idle_en = (ph != 2);
      for (int k = 0; k < 200; k++) begin
        if (ph == 1 && k == 50) hold_req <= 1'b1;
        random_action(ph != 4);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    while (recv_cnt != sent_cnt) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d actions: %0d grants, %0d steals, %0d choking triggers.",
             sent_cnt, grant_cnt, steal_cnt, choke_cnt);
    $display("Six mask settings, directed edge cases and a long receiver hold-off.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout after %0d of %0d results", recv_cnt, sent_cnt);
    $display("TEST FAILED");
    $finish;
  end
endmodule
